>>> src/deq_pkg.sv
// shared constants, types and command codes for the double-ended queue
package deq_pkg;

  localparam int DEPTH     = 1024;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int OCC_W     = $clog2(DEPTH + 1);
  localparam int VAL_W     = 31;
  localparam int RES_W     = 32;
  localparam int TREE_LVLS = (IDX_W + 1) / 2;
  localparam int TREE_N    = 1 << (2 * TREE_LVLS);
  localparam int CNT_W     = $clog2(TREE_LVLS + 1);

  // first node of each level in the flat select tree array
  function automatic int lvl_off(input int lv);
    int acc = 0;
    for (int j = 0; j < lv; j++) begin
      acc += TREE_N >> (2 * (j + 1));
    end
    return acc;
  endfunction

  localparam int NODE_TOT = lvl_off(TREE_LVLS);

  typedef logic [VAL_W-1:0] data_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [OCC_W-1:0] occ_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SIZE       = 3'd4,
    CMD_EMPTY      = 3'd5,
    CMD_FRONT      = 3'd6,
    CMD_BACK       = 3'd7
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_WAIT
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic shift_r;
    logic shift_l;
    logic load_back;
    occ_t occ;
    idx_t last;
  } cell_ctl_t;

endpackage

>>> src/deq_cell.sv
// one storage cell of the deque chain
module deq_cell import deq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  idx_t      pos,
  input  data_t     from_left,
  input  data_t     from_right,
  input  data_t     value,
  output data_t     data,
  output data_t     leaf
);

  always_ff @(posedge clk) begin
    if (ctl.shift_r) begin
      data <= from_left;
    end else if (ctl.shift_l) begin
      data <= from_right;
    end else if (ctl.load_back && (OCC_W'(pos) == ctl.occ)) begin
      data <= value;
    end
  end

  // only the cell holding the back word drives the select tree
  assign leaf = (pos == ctl.last) ? data : '0;

endmodule

>>> src/deq_sel_tree.sv
// registered 4:1 or-tree that picks out the back word from the cell row
module deq_sel_tree import deq_pkg::*; (
  input  logic  clk,
  input  data_t leaf [TREE_N],
  output data_t top
);

  data_t node [NODE_TOT];

  for (genvar lv = 0; lv < TREE_LVLS; lv++) begin : g_lvl
    localparam int NODES = TREE_N >> (2 * (lv + 1));
    localparam int OFF   = lvl_off(lv);
    localparam int PREV  = (lv == 0) ? 0 : lvl_off(lv - 1);
    for (genvar n = 0; n < NODES; n++) begin : g_node
      if (lv == 0) begin : g_leaf
        always_ff @(posedge clk) begin
          node[OFF + n] <= leaf[4*n] | leaf[4*n+1] | leaf[4*n+2] | leaf[4*n+3];
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          node[OFF + n] <= node[PREV + 4*n]     | node[PREV + 4*n + 1] |
                           node[PREV + 4*n + 2] | node[PREV + 4*n + 3];
        end
      end
    end
  end

  assign top = node[NODE_TOT-1];

endmodule

>>> src/double_ended_queue.sv
// double-ended queue of 31-bit words held in a shifting row of cells
//
//   channel   ports                 handshake
//   -------   -------------------   -----------------------------------
//   command   cmd, value            taken when start is high, busy low
//   result    result                valid for one cycle while done high
//
// push, pop front, front, size and empty finish when taken; the result, if any,
// shows the cycle after the command is taken. back and pop back on a non-empty
// deque read through the registered select tree, with busy high meanwhile.
// rst is synchronous and empties the deque; no clearing pass is needed.
// results cannot be held off by the receiver.
module double_ended_queue import deq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              cmd,
  input  logic [VAL_W-1:0]        value,
  output logic signed [RES_W-1:0] result,
  output logic                    done
);

  state_t    state, state_next;
  occ_t      occ, occ_next;
  cnt_t      cnt;
  cell_ctl_t ctl;
  cmd_t      op;
  logic      accept, full, empty, back_go, has_imm, tail_done;
  logic signed [RES_W-1:0] res_imm;
  data_t     cell_data [DEPTH];
  data_t     leaf [TREE_N];
  data_t     back_word;

  assign op     = cmd_t'(cmd);
  assign accept = start && !busy;
  assign full   = (occ == OCC_W'(DEPTH));
  assign empty  = (occ == '0);

  always_comb begin
    ctl.shift_r   = accept && (op == CMD_PUSH_FRONT) && !full;
    ctl.shift_l   = accept && (op == CMD_POP_FRONT) && !empty;
    ctl.load_back = accept && (op == CMD_PUSH_BACK) && !full;
    ctl.occ       = occ;
    ctl.last      = IDX_W'(occ - OCC_W'(1));
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (IDX_W'(i)),
      .from_left  ((i == 0) ? value : cell_data[(i == 0) ? 0 : i-1]),
      .from_right ((i == DEPTH-1) ? data_t'('0) : cell_data[(i == DEPTH-1) ? i : i+1]),
      .value      (value),
      .data       (cell_data[i]),
      .leaf       (leaf[i])
    );
  end

  for (genvar i = DEPTH; i < TREE_N; i++) begin : g_pad
    assign leaf[i] = '0;
  end

  deq_sel_tree u_tree (
    .clk  (clk),
    .leaf (leaf),
    .top  (back_word)
  );

  // occupancy update
  always_comb begin
    occ_next = occ;
    if (accept) begin
      case (op)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (!full) occ_next = occ + OCC_W'(1);
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (!empty) occ_next = occ - OCC_W'(1);
        end
        default: occ_next = occ;
      endcase
    end
  end

  // immediate answers
  always_comb begin
    back_go = accept && !empty && (op inside {CMD_BACK, CMD_POP_BACK});
    has_imm = 1'b0;
    res_imm = '1;
    case (op)
      CMD_SIZE: begin
        has_imm = accept;
        res_imm = RES_W'(occ);
      end
      CMD_EMPTY: begin
        has_imm = accept;
        res_imm = {{(RES_W-1){1'b0}}, empty};
      end
      CMD_POP_FRONT, CMD_FRONT: begin
        has_imm = accept;
        res_imm = empty ? '1 : {1'b0, cell_data[0]};
      end
      CMD_POP_BACK, CMD_BACK: begin
        has_imm = accept && empty;
        res_imm = '1;
      end
      default: begin
        has_imm = 1'b0;
        res_imm = '1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (back_go) state_next = ST_WAIT;
      ST_WAIT: if (cnt == '0) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    busy      = (state == ST_WAIT);
    tail_done = (state == ST_WAIT) && (cnt == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      occ   <= '0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      done  <= has_imm || tail_done;
      if (back_go) begin
        cnt <= CNT_W'(TREE_LVLS - 1);
      end else if (busy && (cnt != '0)) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (has_imm) begin
      result <= res_imm;
    end else if (tail_done) begin
      result <= {1'b0, back_word};
    end
  end

endmodule
